@@ sv/zvc_pkg.sv @@
// Shared types, codes and width helpers for the varint codec.
`default_nettype none

package zvc_pkg;

    localparam int unsigned VAL_W   = 64;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned GROUP_W = 7;
    localparam int unsigned SHIFT_W = 7;
    localparam int unsigned MAX_BYTES = 10;
    localparam int unsigned CNT_W   = 4;

    localparam logic [BYTE_W-1:0] DATA_MASK = 8'h7f;
    localparam logic [BYTE_W-1:0] CONT_BIT  = 8'h80;

    // width_sel codes
    localparam logic [1:0] WSEL_8  = 2'd0;
    localparam logic [1:0] WSEL_16 = 2'd1;
    localparam logic [1:0] WSEL_32 = 2'd2;
    localparam logic [1:0] WSEL_64 = 2'd3;

    // func codes
    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_VALUE    = 2'd1,
        KIND_OVERFLOW = 2'd2
    } kind_t;

    // Sequencer commands to the encode shifter
    typedef struct packed {
        logic load;
        logic step;
    } enc_ctrl_t;

    // Current output byte of the encode shifter
    typedef struct packed {
        logic              last;
        logic [BYTE_W-1:0] enc_byte;
    } enc_stat_t;

    function automatic logic [VAL_W-1:0] width_mask(logic [1:0] sel);
        logic [VAL_W-1:0] m;
        begin
            case (sel)
                WSEL_8:  m = 64'h0000_0000_0000_00ff;
                WSEL_16: m = 64'h0000_0000_0000_ffff;
                WSEL_32: m = 64'h0000_0000_ffff_ffff;
                default: m = '1;
            endcase
            return m;
        end
    endfunction

    function automatic logic [SHIFT_W-1:0] width_bits(logic [1:0] sel);
        logic [SHIFT_W-1:0] w;
        begin
            case (sel)
                WSEL_8:  w = 7'd8;
                WSEL_16: w = 7'd16;
                WSEL_32: w = 7'd32;
                default: w = 7'd64;
            endcase
            return w;
        end
    endfunction

    function automatic logic sign_bit(logic [VAL_W-1:0] v, logic [1:0] sel);
        logic s;
        begin
            case (sel)
                WSEL_8:  s = v[7];
                WSEL_16: s = v[15];
                WSEL_32: s = v[31];
                default: s = v[63];
            endcase
            return s;
        end
    endfunction

endpackage

`default_nettype wire

@@ sv/zvc_encoder.sv @@
// Encode shifter: maps a value and peels off one 7-bit group per step.
`default_nettype none

module zvc_encoder
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire zvc_pkg::enc_ctrl_t            ctrl,
    input  wire logic [1:0]                    width_sel,
    input  wire logic                          is_signed,
    input  wire logic [zvc_pkg::VAL_W-1:0]     in_value,
    output      zvc_pkg::enc_stat_t            stat
);

    logic [zvc_pkg::VAL_W-1:0] val_reg;
    logic [zvc_pkg::VAL_W-1:0] val_next;
    logic [zvc_pkg::CNT_W-1:0] cnt_reg;
    logic [zvc_pkg::CNT_W-1:0] cnt_next;

    logic [zvc_pkg::VAL_W-1:0] mask;
    logic [zvc_pkg::VAL_W-1:0] masked;
    logic [zvc_pkg::VAL_W-1:0] mapped;
    logic                      neg;
    logic                      done;

    assign mask   = zvc_pkg::width_mask(width_sel);
    assign masked = in_value & mask;
    assign neg    = zvc_pkg::sign_bit(masked, width_sel);
    assign mapped = is_signed ? (((masked << 1) ^ {zvc_pkg::VAL_W{neg}}) & mask) : masked;

    // Final group when nothing remains above it, or at the tenth byte
    assign done = ((val_reg >> zvc_pkg::GROUP_W) == '0)
               || (cnt_reg == zvc_pkg::CNT_W'(zvc_pkg::MAX_BYTES - 1));

    assign stat.last     = done;
    assign stat.enc_byte = {~done, val_reg[zvc_pkg::GROUP_W-1:0]};

    always_comb
    begin
        val_next = val_reg;
        cnt_next = cnt_reg;
        if (ctrl.load)
        begin
            val_next = mapped;
            cnt_next = '0;
        end
        else if (ctrl.step)
        begin
            val_next = val_reg >> zvc_pkg::GROUP_W;
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

@@ sv/zigzag_varint_codec_top.sv @@
// Top level of the LEB128 varint codec with optional ZigZag mapping.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per item:
//   func selects encode of in_value or decode of one in_byte, width_sel
//   picks 8/16/32/64 bits, is_signed applies ZigZag mapping.
//   Output channel (out_valid/out_ready) carries result transactions:
//   encoded bytes (out_kind 0), a decoded value (1) or an overflow error (2),
//   with last set on the final result of an input item.
// Flow:
//   Decode: the result is registered in the cycle after accept; a continuation
//   byte that does not overflow gives no result. One byte per cycle when out_ready is high.
//   Encode: the value is loaded into the 7-bit shift unit, then each byte
//   goes from it to the output register, one byte per cycle while out_ready
//   is high, 1 to 10 bytes; the next item is taken once the last byte sits
//   in the output register.
// Reset: clears the sequencer, output valid and the decode accumulator and
//   shift count. A stall on out_ready holds the output register and the
//   sequencer; in_ready stays low until the output register can be written.
`default_nettype none

module zigzag_varint_codec_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic        func,
    input  wire logic [1:0]  width_sel,
    input  wire logic        is_signed,
    input  wire logic [63:0] in_value,
    input  wire logic [7:0]  in_byte,

    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic [1:0]  out_kind,
    output      logic [7:0]  out_byte,
    output      logic [63:0] out_value,
    output      logic        last
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_ENC  = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic                                  out_valid_reg, out_valid_next;
    zvc_pkg::kind_t                        kind_reg, kind_next;
    logic [zvc_pkg::BYTE_W-1:0]            byte_reg, byte_next;
    logic [zvc_pkg::VAL_W-1:0]             value_reg, value_next;
    logic                                  last_reg, last_next;

    logic [zvc_pkg::VAL_W-1:0]             acc_reg, acc_next;
    logic [zvc_pkg::SHIFT_W-1:0]           shift_reg, shift_next;

    zvc_pkg::enc_ctrl_t                    enc_ctrl;
    zvc_pkg::enc_stat_t                    enc_stat;

    logic                                  out_free;
    logic                                  in_fire;
    logic [zvc_pkg::VAL_W-1:0]             mask;
    logic [zvc_pkg::VAL_W-1:0]             acc_upd;
    logic [zvc_pkg::VAL_W-1:0]             dec_val;
    logic [zvc_pkg::SHIFT_W-1:0]           shift_add;
    logic                                  overflow;

    zvc_encoder u_enc
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (enc_ctrl),
        .width_sel (width_sel),
        .is_signed (is_signed),
        .in_value  (in_value),
        .stat      (enc_stat)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;

    // Decode datapath: merge the 7 data bits at the current group position
    assign mask = zvc_pkg::width_mask(width_sel);

    always_comb
    begin
        if (shift_reg[zvc_pkg::SHIFT_W-1])
        begin
            acc_upd = acc_reg & mask;
        end
        else
        begin
            acc_upd = (acc_reg | ({57'b0, in_byte[zvc_pkg::GROUP_W-1:0]}
                       << shift_reg[zvc_pkg::SHIFT_W-2:0])) & mask;
        end
    end

    assign dec_val   = is_signed
                     ? (((acc_upd >> 1) ^ {zvc_pkg::VAL_W{acc_upd[0]}}) & mask)
                     : acc_upd;
    assign shift_add = shift_reg + zvc_pkg::SHIFT_W'(zvc_pkg::GROUP_W);
    assign overflow  = shift_add > zvc_pkg::width_bits(width_sel);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        acc_next       = acc_reg;
        shift_next     = shift_reg;
        enc_ctrl.load  = 1'b0;
        enc_ctrl.step  = 1'b0;

        // drop the output once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (func == zvc_pkg::FUNC_ENCODE)
                    begin
                        enc_ctrl.load = 1'b1;
                        state_next    = S_ENC;
                    end
                    else if (!in_byte[zvc_pkg::BYTE_W-1])
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = zvc_pkg::KIND_VALUE;
                        byte_next      = '0;
                        value_next     = dec_val;
                        last_next      = 1'b1;
                        acc_next       = '0;
                        shift_next     = '0;
                    end
                    else if (overflow)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = zvc_pkg::KIND_OVERFLOW;
                        byte_next      = '0;
                        value_next     = '0;
                        last_next      = 1'b1;
                        acc_next       = '0;
                        shift_next     = '0;
                    end
                    else
                    begin
                        // advance to the next group, no result yet
                        acc_next   = acc_upd;
                        shift_next = shift_add;
                    end
                end
            end
            S_ENC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = zvc_pkg::KIND_BYTE;
                    byte_next      = enc_stat.enc_byte;
                    value_next     = '0;
                    last_next      = enc_stat.last;
                    if (enc_stat.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        enc_ctrl.step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            shift_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            shift_reg     <= shift_next;
        end
    end

    // Output payload holds while stalled
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        byte_reg  <= byte_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = byte_reg;
    assign out_value = value_reg;
    assign last      = last_reg;

`ifndef SYNTH
    a_cont_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind == zvc_pkg::KIND_BYTE && !last) |-> out_byte[7])
        else $error("non-final encoded byte lacks continuation bit");

    a_last_no_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind == zvc_pkg::KIND_BYTE && last) |-> !out_byte[7])
        else $error("final encoded byte carries continuation bit");

    a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
        shift_reg <= 7'd64)
        else $error("decode shift count passed the widest value");

    a_enc_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && func == zvc_pkg::FUNC_ENCODE) |=> state_reg == S_ENC)
        else $error("encode transaction did not start the shifter");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind != zvc_pkg::KIND_VALUE) |-> out_value == 64'd0)
        else $error("value field not zero on a non-value result");
`endif

endmodule

`default_nettype wire
